@@ rtl/assert_macros.svh @@
// Assertion shorthands shared by the occupancy counter RTL.
// No dependencies; take in by include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPOC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BPOC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/bpoc_pkg.sv @@
// Shared types and constants for the beam pair occupancy counter.
// No dependencies.
`default_nettype none

package bpoc_pkg;

    localparam int SAMPLE_BITS     = 10;
    localparam int COUNT_BITS_DEF  = 8;
    localparam int OCC_BITS        = 8;
    localparam int LIMIT_BITS      = 8;
    localparam int TIME_BITS       = 32;
    localparam int THRESH_BITS     = 10;
    localparam int PHASE_BITS      = 2;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PEOPLE       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME_MS     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANGE_THRESHOLD = 2'd2;

    localparam logic [PHASE_BITS-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_IN   = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_OUT  = 2'd2;

    localparam logic [LIMIT_BITS-1:0]  MAX_PEOPLE_RST       = 8'd2;
    localparam logic [TIME_BITS-1:0]   HOLD_TIME_RST        = 32'd10000;
    localparam logic [THRESH_BITS-1:0] CHANGE_THRESHOLD_RST = 10'd150;
    localparam int                     SAMPLE_RST           = 700;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] outer_sample;
        logic [SAMPLE_BITS-1:0] inner_sample;
        logic [TIME_BITS-1:0]   now_ms;
    } in_beat_t;

    typedef struct packed {
        logic [OCC_BITS-1:0]   occupancy;
        logic                  light_on;
        logic                  buzzer_on;
        logic [PHASE_BITS-1:0] direction_phase;
    } out_beat_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  light;
        logic                  buzzer;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/bpoc_step.sv @@
// Next-state logic for one sample pair: phase tracking, count update, alarms.
// Depends on bpoc_pkg.
`default_nettype none

module bpoc_step #(
    parameter int COUNT_BITS = bpoc_pkg::COUNT_BITS_DEF
) (
    input  var bpoc_pkg::in_beat_t                  beat,
    input  var bpoc_pkg::status_t                   status_cur,
    input  var logic [COUNT_BITS-1:0]               count_cur,
    input  var logic [bpoc_pkg::TIME_BITS-1:0]      over_since_cur,
    input  var logic [bpoc_pkg::SAMPLE_BITS-1:0]    prev_outer,
    input  var logic [bpoc_pkg::SAMPLE_BITS-1:0]    prev_inner,
    input  var logic [bpoc_pkg::LIMIT_BITS-1:0]     max_people,
    input  var logic [bpoc_pkg::TIME_BITS-1:0]      hold_time_ms,
    input  var logic [bpoc_pkg::THRESH_BITS-1:0]    change_threshold,
    output bpoc_pkg::status_t                       status_next,
    output logic [COUNT_BITS-1:0]                   count_next,
    output logic [bpoc_pkg::TIME_BITS-1:0]          over_since_next
);
    import bpoc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [SAMPLE_BITS-1:0] thr;
    logic rise_o, rise_i, fall_o, fall_i;
    logic was_over, is_over;
    logic [TIME_BITS-1:0] elapsed;

    assign thr = SAMPLE_BITS'(change_threshold);

    assign rise_o = (beat.outer_sample > prev_outer) && ((beat.outer_sample - prev_outer) > thr);
    assign rise_i = (beat.inner_sample > prev_inner) && ((beat.inner_sample - prev_inner) > thr);
    assign fall_o = (prev_outer > beat.outer_sample) && ((prev_outer - beat.outer_sample) > thr);
    assign fall_i = (prev_inner > beat.inner_sample) && ((prev_inner - beat.inner_sample) > thr);

    assign elapsed = beat.now_ms - over_since_cur;

    always_comb begin
        count_next        = count_cur;
        status_next.phase = PH_IDLE;
        unique case (status_cur.phase)
            PH_IN: begin
                if (!fall_o && fall_i) begin
                    if (count_cur != COUNT_MAX) begin
                        count_next = count_cur + COUNT_BITS'(1);
                    end
                    status_next.phase = PH_IDLE;
                end else if (fall_o && !fall_i) begin
                    status_next.phase = PH_IDLE;
                end else begin
                    status_next.phase = PH_IN;
                end
            end
            PH_OUT: begin
                if (fall_o && !fall_i) begin
                    if (count_cur != '0) begin
                        count_next = count_cur - COUNT_BITS'(1);
                    end
                    status_next.phase = PH_IDLE;
                end else begin
                    status_next.phase = PH_OUT;
                end
            end
            default: begin
                priority if (rise_o) begin
                    status_next.phase = PH_IN;
                end else if (rise_i) begin
                    status_next.phase = PH_OUT;
                end else begin
                    status_next.phase = PH_IDLE;
                end
            end
        endcase
    end

    assign was_over = CMP_W'(count_cur)  > CMP_W'(max_people);
    assign is_over  = CMP_W'(count_next) > CMP_W'(max_people);

    always_comb begin
        status_next.light  = status_cur.light;
        status_next.buzzer = status_cur.buzzer;
        over_since_next    = over_since_cur;
        if (!was_over && is_over) begin
            status_next.light = 1'b1;
            over_since_next   = beat.now_ms;
        end else if (was_over && is_over) begin
            if (elapsed > hold_time_ms) begin
                status_next.buzzer = 1'b1;
            end
        end else if (was_over && !is_over) begin
            status_next.light  = 1'b0;
            status_next.buzzer = 1'b0;
            over_since_next    = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bpoc_skid.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on bpoc_pkg and assert_macros.svh.
`default_nettype none

module bpoc_skid (
    input  var logic                 aclk,
    input  var logic                 aresetn,
    input  var logic                 in_valid,
    output logic                     in_ready,
    input  var bpoc_pkg::out_beat_t  in_data,
    output logic                     m_valid,
    input  var logic                 m_ready,
    output bpoc_pkg::out_beat_t      m_data
);
    import bpoc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_beat_t out_reg, out_next;
    out_beat_t skid_reg, skid_next;
    logic      push, pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push && out_valid_reg && !pop) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end else if (push) begin
            out_next       = in_data;
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`include "assert_macros.svh"

    `BPOC_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `BPOC_ASSERT_NEXT(a_stalled_push_skids, aclk, aresetn,
        aresetn && push && out_valid_reg && !m_ready, skid_valid_reg)

endmodule

`default_nettype wire

@@ rtl/beam_pair_occupancy_counter.sv @@
// Beam pair occupancy counter, top level.
// A result beat is registered in the output buffer when its input is accepted.
// Throughput: one beat per cycle while skid is empty, updating count and phase.
// A two-entry output buffer keeps input accepted while one result is stalled.
// Reset (aresetn low, synchronous): idle phase, count 0, flags clear, previous
// samples 700, registers back to their defaults, no result pending.
`default_nettype none

module beam_pair_occupancy_counter #(
    parameter int COUNT_BITS = bpoc_pkg::COUNT_BITS_DEF
) (
    input  var logic                                aclk,
    input  var logic                                aresetn,
    input  var logic                                cfg_wr_en,
    input  var logic [bpoc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  var logic [bpoc_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  var logic                                s_valid,
    output logic                                    s_ready,
    input  var bpoc_pkg::in_beat_t                  s_data,
    output logic                                    m_valid,
    input  var logic                                m_ready,
    output bpoc_pkg::out_beat_t                     m_data
);
    import bpoc_pkg::*;

    logic [LIMIT_BITS-1:0]  max_people_reg;
    logic [TIME_BITS-1:0]   hold_time_reg;
    logic [THRESH_BITS-1:0] threshold_reg;

    status_t                status_reg, status_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [TIME_BITS-1:0]   over_since_reg, over_since_next;
    logic [SAMPLE_BITS-1:0] prev_outer_reg, prev_inner_reg;

    logic      accept;
    out_beat_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_people_reg <= MAX_PEOPLE_RST;
            hold_time_reg  <= HOLD_TIME_RST;
            threshold_reg  <= CHANGE_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_PEOPLE:       max_people_reg <= cfg_wr_data[LIMIT_BITS-1:0];
                CFG_HOLD_TIME_MS:     hold_time_reg  <= cfg_wr_data[TIME_BITS-1:0];
                CFG_CHANGE_THRESHOLD: threshold_reg  <= cfg_wr_data[THRESH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    bpoc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .beat             (s_data),
        .status_cur       (status_reg),
        .count_cur        (count_reg),
        .over_since_cur   (over_since_reg),
        .prev_outer       (prev_outer_reg),
        .prev_inner       (prev_inner_reg),
        .max_people       (max_people_reg),
        .hold_time_ms     (hold_time_reg),
        .change_threshold (threshold_reg),
        .status_next      (status_next),
        .count_next       (count_next),
        .over_since_next  (over_since_next)
    );

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= '{phase: PH_IDLE, light: 1'b0, buzzer: 1'b0};
            count_reg      <= '0;
            over_since_reg <= '0;
            prev_outer_reg <= SAMPLE_BITS'(SAMPLE_RST);
            prev_inner_reg <= SAMPLE_BITS'(SAMPLE_RST);
        end else if (accept) begin
            status_reg     <= status_next;
            count_reg      <= count_next;
            over_since_reg <= over_since_next;
            prev_outer_reg <= s_data.outer_sample;
            prev_inner_reg <= s_data.inner_sample;
        end
    end

    assign result.occupancy       = OCC_BITS'(count_next);
    assign result.light_on        = status_next.light;
    assign result.buzzer_on       = status_next.buzzer;
    assign result.direction_phase = status_next.phase;

    bpoc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`include "assert_macros.svh"

    `BPOC_ASSERT_NEXT(a_count_holds_idle, aclk, aresetn,
        aresetn && !accept, $stable(count_reg) && $stable(status_reg))
    `BPOC_ASSERT_NEXT(a_prev_tracks_beat, aclk, aresetn,
        aresetn && accept, prev_outer_reg == $past(s_data.outer_sample))

endmodule

`default_nettype wire

@@ tb/tb_beam_pair_occupancy_counter.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for beam_pair_occupancy_counter: tracks count, phase and flags
// per sample beat and compares every result beat. Depends on bpoc_pkg and the top level.

module tb_beam_pair_occupancy_counter;
    import bpoc_pkg::*;

    typedef enum {RX_FREE, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_pattern_t;

    localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_MAX_PEOPLE;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_beat_t                 s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_beat_t                m_data;

    in_beat_t  sample_queue[$];
    out_beat_t status_due[$];
    int        errors = 0;
    int        beats_in = 0;
    logic      in_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        holds_done = 0;
    int        mode_left = 0;
    rx_pattern_t ready_mode = RX_FREE;
    logic [TIME_BITS-1:0] now_t = '0;

    // occupancy tracking state and register copies
    logic [PHASE_BITS-1:0]     cur_phase;
    logic [SAMPLE_BITS-1:0]    last_outer;
    logic [SAMPLE_BITS-1:0]    last_inner;
    logic [COUNT_BITS_DEF-1:0] head_count;
    logic [TIME_BITS-1:0]      over_start;
    logic                      light_st;
    logic                      buzz_st;
    logic [LIMIT_BITS-1:0]     limit_cfg;
    logic [TIME_BITS-1:0]      hold_cfg;
    logic [THRESH_BITS-1:0]    thr_cfg;

    beam_pair_occupancy_counter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("beam_pair_occupancy_counter regression: fail");
        $finish;
    end

    function automatic bit beam_moved(logic [SAMPLE_BITS-1:0] was,
                                      logic [SAMPLE_BITS-1:0] now_v, bit rising);
        int d;
        d = int'(now_v) - int'(was);
        if (!rising) d = -d;
        return d > int'(thr_cfg);
    endfunction

    function automatic out_beat_t step_occupancy(in_beat_t b);
        logic [COUNT_BITS_DEF-1:0] prior;
        logic [PHASE_BITS-1:0]     next_ph;
        logic                      fo, fi, was_over, is_over;
        out_beat_t                 r;
        prior = head_count;
        next_ph = PH_IDLE;
        fo = beam_moved(last_outer, b.outer_sample, 1'b0);
        fi = beam_moved(last_inner, b.inner_sample, 1'b0);
        case (cur_phase)
            PH_IN: begin
                if (!fo && fi) begin
                    if (head_count != COUNT_TOP) head_count = head_count + 1'b1;
                end else if (!fo || fi) begin
                    next_ph = PH_IN;
                end
            end
            PH_OUT: begin
                if (fo && !fi) begin
                    if (head_count != '0) head_count = head_count - 1'b1;
                end else begin
                    next_ph = PH_OUT;
                end
            end
            default: begin
                if (beam_moved(last_outer, b.outer_sample, 1'b1)) next_ph = PH_IN;
                else if (beam_moved(last_inner, b.inner_sample, 1'b1)) next_ph = PH_OUT;
            end
        endcase
        was_over = prior > limit_cfg;
        is_over = head_count > limit_cfg;
        if (!was_over && is_over) begin
            light_st = 1'b1;
            over_start = b.now_ms;
        end else if (was_over && is_over) begin
            if (TIME_BITS'(b.now_ms - over_start) > hold_cfg) buzz_st = 1'b1;
        end else if (was_over && !is_over) begin
            light_st = 1'b0;
            buzz_st = 1'b0;
            over_start = '0;
        end
        cur_phase = next_ph;
        last_outer = b.outer_sample;
        last_inner = b.inner_sample;
        r.occupancy = head_count[OCC_BITS-1:0];
        r.light_on = light_st;
        r.buzzer_on = buzz_st;
        r.direction_phase = cur_phase;
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] next_ms();
        if ($urandom_range(0, 15) == 0) now_t = now_t + $urandom;
        else now_t = now_t + $urandom_range(0, 12);
        return now_t;
    endfunction

    task automatic push_beat(int o, int i, logic [TIME_BITS-1:0] t);
        in_beat_t b;
        b.outer_sample = o[SAMPLE_BITS-1:0];
        b.inner_sample = i[SAMPLE_BITS-1:0];
        b.now_ms = t;
        sample_queue.push_back(b);
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_valid || status_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MAX_PEOPLE:       limit_cfg = val[LIMIT_BITS-1:0];
            CFG_HOLD_TIME_MS:     hold_cfg = val[TIME_BITS-1:0];
            CFG_CHANGE_THRESHOLD: thr_cfg = val[THRESH_BITS-1:0];
            default: ;
        endcase
    endtask

    // enter, leave, cancel and both-fall sequences on random levels, plus noise
    task automatic random_mix(int n);
        int made, kind, d, lo_o, lo_i, hi_o, hi_i;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(0, 9);
            d = int'(thr_cfg) + 1 + $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) d = int'(thr_cfg);
            if (d > 1023) d = 1023;
            lo_o = $urandom_range(0, 1023 - d);
            lo_i = $urandom_range(0, 1023 - d);
            hi_o = lo_o + d;
            hi_i = lo_i + d;
            if (kind <= 2) begin
                push_beat(lo_o, lo_i, next_ms());
                push_beat(hi_o, lo_i, next_ms());
                push_beat(hi_o, hi_i, next_ms());
                push_beat(hi_o, lo_i, next_ms());
                made += 4;
            end else if (kind <= 5) begin
                push_beat(lo_o, lo_i, next_ms());
                push_beat(lo_o, hi_i, next_ms());
                push_beat(hi_o, hi_i, next_ms());
                push_beat(lo_o, hi_i, next_ms());
                made += 4;
            end else if (kind == 6) begin
                push_beat(lo_o, lo_i, next_ms());
                push_beat(hi_o, lo_i, next_ms());
                push_beat(lo_o, lo_i, next_ms());
                made += 3;
            end else if (kind == 7) begin
                push_beat(lo_o, lo_i, next_ms());
                push_beat(hi_o, lo_i, next_ms());
                push_beat(hi_o, hi_i, next_ms());
                push_beat(lo_o, lo_i, next_ms());
                made += 4;
            end else begin
                push_beat($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
                made += 1;
            end
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= sample_queue.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that changes over time, plus two long hold-offs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ((holds_done == 0 && beats_in >= 120) ||
                     (holds_done == 1 && beats_in >= 600)) begin
            holds_done <= holds_done + 1;
            stall_left <= 80;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(16, 96);
                ready_mode <= rx_pattern_t'($urandom_range(0, 3));
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_HALF:   m_ready <= ($urandom_range(0, 1) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_proc
        out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    $error("result beat with nothing expected: %p", m_data);
                    errors++;
                end else begin
                    want = status_due.pop_front();
                    if (m_data.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_data.occupancy);
                        errors++;
                    end
                    if (m_data.light_on !== want.light_on) begin
                        $error("light_on: expected %0b, got %0b",
                               want.light_on, m_data.light_on);
                        errors++;
                    end
                    if (m_data.buzzer_on !== want.buzzer_on) begin
                        $error("buzzer_on: expected %0b, got %0b",
                               want.buzzer_on, m_data.buzzer_on);
                        errors++;
                    end
                    if (m_data.direction_phase !== want.direction_phase) begin
                        $error("direction_phase: expected %0d, got %0d",
                               want.direction_phase, m_data.direction_phase);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                status_due.push_back(step_occupancy(s_data));
                beats_in <= beats_in + 1;
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
        end
    end

    initial begin : main_seq
        int k, x;
        cur_phase = PH_IDLE;
        last_outer = SAMPLE_BITS'(SAMPLE_RST);
        last_inner = SAMPLE_BITS'(SAMPLE_RST);
        head_count = '0;
        over_start = '0;
        light_st = 1'b0;
        buzz_st = 1'b0;
        limit_cfg = MAX_PEOPLE_RST;
        hold_cfg = HOLD_TIME_RST;
        thr_cfg = CHANGE_THRESHOLD_RST;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // leave at zero count, threshold boundary, both rise, count, cancel
        push_beat(700, 851, 0);
        push_beat(549, 851, 1);
        push_beat(699, 851, 2);
        push_beat(1023, 1023, 3);
        push_beat(1023, 1023, 4);
        push_beat(1023, 0, 5);
        push_beat(0, 0, 6);
        push_beat(1023, 0, 7);
        push_beat(0, 0, 8);
        // both fall while entering, then count in
        push_beat(1023, 0, 9);
        push_beat(1023, 1023, 10);
        push_beat(0, 0, 11);
        push_beat(0, 1023, 12);
        push_beat(0, 0, 13);
        // go over the limit near the timestamp wrap, then cross the hold time
        push_beat(1023, 1023, 32'hFFFF_FF00);
        push_beat(1023, 0, 32'hFFFF_FF01);
        push_beat(0, 0, 32'h0000_2611);
        push_beat(0, 0, 32'h0000_2612);
        // leave back down to the limit
        push_beat(0, 1023, 32'h0000_2613);
        push_beat(1023, 1023, 32'h0000_2614);
        push_beat(0, 1023, 32'h0000_2615);
        push_beat(0, 0, 32'hFFFF_FFFF);
        wait_drained();

        write_reg(CFG_MAX_PEOPLE, 32'd0);
        write_reg(CFG_HOLD_TIME_MS, 32'd0);
        write_reg(CFG_CHANGE_THRESHOLD, 32'd0);
        now_t = $urandom;
        random_mix(150);
        wait_drained();

        write_reg(CFG_MAX_PEOPLE, $urandom_range(1, 6));
        write_reg(CFG_HOLD_TIME_MS, $urandom_range(0, 300));
        write_reg(CFG_CHANGE_THRESHOLD, $urandom_range(20, 300));
        random_mix(200);
        wait_drained();

        // count up to saturation with a slowly rising outer level
        write_reg(CFG_MAX_PEOPLE, 32'd3);
        write_reg(CFG_HOLD_TIME_MS, 32'd20);
        write_reg(CFG_CHANGE_THRESHOLD, 32'd0);
        push_beat(1023, 1023, next_ms());
        push_beat(0, 1023, next_ms());
        push_beat(0, 0, next_ms());
        for (k = 1; k <= 270; k++) begin
            x = $urandom_range(0, 1022);
            push_beat(k, x + 1, next_ms());
            push_beat(k, x, next_ms());
        end
        wait_drained();

        write_reg(CFG_MAX_PEOPLE, 32'd255);
        write_reg(CFG_HOLD_TIME_MS, 32'hFFFF_FFFF);
        write_reg(CFG_CHANGE_THRESHOLD, 32'd1023);
        random_mix(30);
        wait_drained();

        repeat (4) @(posedge aclk);
        if (errors == 0 && status_due.size() == 0)
            $display("beam_pair_occupancy_counter regression: pass");
        else
            $display("beam_pair_occupancy_counter regression: fail");
        $finish;
    end

endmodule
